// ----- hw/rtl/vgcd_pkg.sv -----
package vgcd_pkg;

    localparam int MAX_AXIS_NODES = 32;
    localparam int STORE_DEPTH    = 32768;
    localparam int ADDR_W         = $clog2(STORE_DEPTH);
    localparam int NODE_W         = 5;
    localparam int SIZE_W         = 6;
    localparam int INV_W          = 16;
    localparam int SAMPLE_W       = 16;
    localparam int GRAD_W         = 25;
    localparam int QUEUE_DEPTH    = 2;
    localparam int CFG_IDX_W      = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SPACING_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SPACING_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SPACING_Z = 3'd5;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;
    localparam logic [INV_W-1:0]  INV_RESET  = 16'd256;

    localparam logic [ADDR_W-1:0] STRIDE_X = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] STRIDE_Y = ADDR_W'(MAX_AXIS_NODES);
    localparam logic [ADDR_W-1:0] STRIDE_Z = ADDR_W'(MAX_AXIS_NODES * MAX_AXIS_NODES);

    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_QUERY,
        KIND_SKIP
    } kind_t;

    typedef struct packed {
        kind_t                       kind;
        logic                        index_error;
        logic [ADDR_W-1:0]           addr;
        logic [2:0]                  has_pos;
        logic [2:0]                  has_neg;
        logic signed [SAMPLE_W-1:0]  sample;
    } cmd_t;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] r;
        if (s == '0)
        begin
            r = SIZE_W'(1);
        end
        else if (s > SIZE_W'(MAX_AXIS_NODES))
        begin
            r = SIZE_W'(MAX_AXIS_NODES);
        end
        else
        begin
            r = s;
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/volume_gradient_central_difference.sv -----
// Central-difference gradient over a 32x32x32 grid of Q8.8 signed-distance
// samples held in a single-port store (contents undefined until written; no
// clearing pass). An item is taken when start is high and busy is low; a
// two-entry command queue lets up to two items wait while the execution side
// works, and busy is high only while that queue is full. Each item produces
// exactly one result, shown for one cycle with done high; the receiver cannot
// stall, so capture it on that cycle. A query makes six neighbor reads through
// the one store port, waits for the registered read data, then forms three
// products through one shared 17x17 multiplier with its rounding shift, then
// shows the result. A write passes a store-write state; an out-of-grid item
// goes straight to the result. Write configuration only while idle.
module volume_gradient_central_difference (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 action,
    input  logic [vgcd_pkg::NODE_W-1:0]          node_x,
    input  logic [vgcd_pkg::NODE_W-1:0]          node_y,
    input  logic [vgcd_pkg::NODE_W-1:0]          node_z,
    input  logic signed [vgcd_pkg::SAMPLE_W-1:0] sample,
    output logic                                 done,
    output logic signed [vgcd_pkg::GRAD_W-1:0]   grad_x,
    output logic signed [vgcd_pkg::GRAD_W-1:0]   grad_y,
    output logic signed [vgcd_pkg::GRAD_W-1:0]   grad_z,
    output logic                                 index_error,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [vgcd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [vgcd_pkg::INV_W-1:0]           cfg_data
);

    logic [vgcd_pkg::SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [vgcd_pkg::INV_W-1:0]  inv_x_reg, inv_y_reg, inv_z_reg;

    vgcd_pkg::cmd_t front_cmd;
    vgcd_pkg::cmd_t head_cmd;
    logic           q_valid;
    logic           q_full;
    logic           q_pop;
    logic           push;

    assign cfg_ready = 1'b1;
    assign busy      = q_full;
    assign push      = start && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= vgcd_pkg::SIZE_RESET;
            size_y_reg <= vgcd_pkg::SIZE_RESET;
            size_z_reg <= vgcd_pkg::SIZE_RESET;
            inv_x_reg  <= vgcd_pkg::INV_RESET;
            inv_y_reg  <= vgcd_pkg::INV_RESET;
            inv_z_reg  <= vgcd_pkg::INV_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                vgcd_pkg::CFG_SIZE_X:        size_x_reg <= cfg_data[vgcd_pkg::SIZE_W-1:0];
                vgcd_pkg::CFG_SIZE_Y:        size_y_reg <= cfg_data[vgcd_pkg::SIZE_W-1:0];
                vgcd_pkg::CFG_SIZE_Z:        size_z_reg <= cfg_data[vgcd_pkg::SIZE_W-1:0];
                vgcd_pkg::CFG_INV_SPACING_X: inv_x_reg  <= cfg_data;
                vgcd_pkg::CFG_INV_SPACING_Y: inv_y_reg  <= cfg_data;
                vgcd_pkg::CFG_INV_SPACING_Z: inv_z_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    vgcd_front u_front (
        .action (action),
        .node_x (node_x),
        .node_y (node_y),
        .node_z (node_z),
        .sample (sample),
        .size_x (size_x_reg),
        .size_y (size_y_reg),
        .size_z (size_z_reg),
        .cmd    (front_cmd)
    );

    vgcd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (front_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .valid    (q_valid),
        .full     (q_full)
    );

    vgcd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_cmd       (head_cmd),
        .pop         (q_pop),
        .inv_x       (inv_x_reg),
        .inv_y       (inv_y_reg),
        .inv_z       (inv_z_reg),
        .done        (done),
        .grad_x      (grad_x),
        .grad_y      (grad_y),
        .grad_z      (grad_z),
        .index_error (index_error)
    );

endmodule

// ----- hw/rtl/vgcd_front.sv -----
module vgcd_front (
    input  logic                                 action,
    input  logic [vgcd_pkg::NODE_W-1:0]          node_x,
    input  logic [vgcd_pkg::NODE_W-1:0]          node_y,
    input  logic [vgcd_pkg::NODE_W-1:0]          node_z,
    input  logic signed [vgcd_pkg::SAMPLE_W-1:0] sample,
    input  logic [vgcd_pkg::SIZE_W-1:0]          size_x,
    input  logic [vgcd_pkg::SIZE_W-1:0]          size_y,
    input  logic [vgcd_pkg::SIZE_W-1:0]          size_z,
    output vgcd_pkg::cmd_t                       cmd
);

    logic [vgcd_pkg::SIZE_W-1:0] sx, sy, sz;
    logic [vgcd_pkg::SIZE_W-1:0] ex, ey, ez;
    logic                        err;

    assign sx = vgcd_pkg::eff_size(size_x);
    assign sy = vgcd_pkg::eff_size(size_y);
    assign sz = vgcd_pkg::eff_size(size_z);

    assign ex = {1'b0, node_x};
    assign ey = {1'b0, node_y};
    assign ez = {1'b0, node_z};

    assign err = (ex >= sx) || (ey >= sy) || (ez >= sz);

    always_comb
    begin
        cmd.index_error = err;
        if (err)
        begin
            cmd.kind = vgcd_pkg::KIND_SKIP;
        end
        else if (action)
        begin
            cmd.kind = vgcd_pkg::KIND_QUERY;
        end
        else
        begin
            cmd.kind = vgcd_pkg::KIND_WRITE;
        end
        cmd.addr = vgcd_pkg::ADDR_W'(32'(node_x)
                   + 32'(vgcd_pkg::MAX_AXIS_NODES) * (32'(node_y)
                   + 32'(vgcd_pkg::MAX_AXIS_NODES) * 32'(node_z)));
        cmd.has_pos = {(ez + 6'd1) < sz, (ey + 6'd1) < sy, (ex + 6'd1) < sx};
        cmd.has_neg = {node_z != '0, node_y != '0, node_x != '0};
        cmd.sample  = sample;
    end

endmodule

// ----- hw/rtl/vgcd_queue.sv -----
module vgcd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  vgcd_pkg::cmd_t push_cmd,
    input  logic           pop,
    output vgcd_pkg::cmd_t head_cmd,
    output logic           valid,
    output logic           full
);

    localparam int PTR_W = $clog2(vgcd_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(vgcd_pkg::QUEUE_DEPTH + 1);

    vgcd_pkg::cmd_t   entry_reg [vgcd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign valid    = count_reg != '0;
    assign full     = count_reg == CNT_W'(vgcd_pkg::QUEUE_DEPTH);
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(vgcd_pkg::QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(vgcd_pkg::QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> (!full || pop))
        else $error("queue overflow");

endmodule

// ----- hw/rtl/vgcd_back.sv -----
module vgcd_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 q_valid,
    input  vgcd_pkg::cmd_t                       q_cmd,
    output logic                                 pop,
    input  logic [vgcd_pkg::INV_W-1:0]           inv_x,
    input  logic [vgcd_pkg::INV_W-1:0]           inv_y,
    input  logic [vgcd_pkg::INV_W-1:0]           inv_z,
    output logic                                 done,
    output logic signed [vgcd_pkg::GRAD_W-1:0]   grad_x,
    output logic signed [vgcd_pkg::GRAD_W-1:0]   grad_y,
    output logic signed [vgcd_pkg::GRAD_W-1:0]   grad_z,
    output logic                                 index_error
);

    localparam int PROD_W = 2 * (vgcd_pkg::SAMPLE_W + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_MUL,
        ST_OUT
    } state_t;

    state_t                               state_reg;
    logic [2:0]                           step_reg;
    vgcd_pkg::cmd_t                       cmd_reg;
    logic signed [vgcd_pkg::SAMPLE_W-1:0] smp_reg [6];
    logic signed [PROD_W-1:0]             prod_reg;
    logic signed [vgcd_pkg::GRAD_W-1:0]   grad_reg [3];
    logic                                 err_reg;
    logic                                 done_reg;

    logic [vgcd_pkg::SAMPLE_W-1:0] mem [vgcd_pkg::STORE_DEPTH];
    logic [vgcd_pkg::SAMPLE_W-1:0] mem_q;
    logic [vgcd_pkg::ADDR_W-1:0]   mem_addr;
    logic                          mem_we;

    logic [vgcd_pkg::ADDR_W-1:0]   stride;
    logic                          step_pos, step_neg;
    logic [vgcd_pkg::ADDR_W-1:0]   rd_addr;

    logic signed [vgcd_pkg::SAMPLE_W-1:0] smp_a, smp_b;
    logic [vgcd_pkg::INV_W-1:0]           inv_sel;
    logic signed [vgcd_pkg::SAMPLE_W:0]   diff;
    logic signed [PROD_W-1:0]             diff_w, inv_w, prod_next;
    logic signed [PROD_W-1:0]             shifted;

    assign pop = (state_reg == ST_IDLE) && q_valid;

    always_comb
    begin
        unique case (step_reg[2:1])
            2'd0:
            begin
                stride   = vgcd_pkg::STRIDE_X;
                step_pos = cmd_reg.has_pos[0];
                step_neg = cmd_reg.has_neg[0];
            end
            2'd1:
            begin
                stride   = vgcd_pkg::STRIDE_Y;
                step_pos = cmd_reg.has_pos[1];
                step_neg = cmd_reg.has_neg[1];
            end
            2'd2:
            begin
                stride   = vgcd_pkg::STRIDE_Z;
                step_pos = cmd_reg.has_pos[2];
                step_neg = cmd_reg.has_neg[2];
            end
            default:
            begin
                stride   = '0;
                step_pos = 1'b0;
                step_neg = 1'b0;
            end
        endcase
        if (step_reg[0])
        begin
            rd_addr = step_neg ? cmd_reg.addr - stride : cmd_reg.addr;
        end
        else
        begin
            rd_addr = step_pos ? cmd_reg.addr + stride : cmd_reg.addr;
        end
    end

    assign mem_we   = state_reg == ST_WRITE;
    assign mem_addr = mem_we ? cmd_reg.addr : rd_addr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= cmd_reg.sample;
        end
        mem_q <= mem[mem_addr];
    end

    always_comb
    begin
        unique case (step_reg[1:0])
            2'd0:
            begin
                smp_a   = smp_reg[0];
                smp_b   = smp_reg[1];
                inv_sel = inv_x;
            end
            2'd1:
            begin
                smp_a   = smp_reg[2];
                smp_b   = smp_reg[3];
                inv_sel = inv_y;
            end
            2'd2:
            begin
                smp_a   = smp_reg[4];
                smp_b   = smp_reg[5];
                inv_sel = inv_z;
            end
            default:
            begin
                smp_a   = '0;
                smp_b   = '0;
                inv_sel = '0;
            end
        endcase
    end

    // product for the axis at step; rounding shift for the axis one step behind
    always_comb
    begin
        logic both_prev;
        both_prev = 1'b0;
        unique case (step_reg[1:0])
            2'd1:    both_prev = cmd_reg.has_pos[0] & cmd_reg.has_neg[0];
            2'd2:    both_prev = cmd_reg.has_pos[1] & cmd_reg.has_neg[1];
            2'd3:    both_prev = cmd_reg.has_pos[2] & cmd_reg.has_neg[2];
            default: both_prev = 1'b0;
        endcase
        diff      = $signed({smp_a[vgcd_pkg::SAMPLE_W-1], smp_a})
                    - $signed({smp_b[vgcd_pkg::SAMPLE_W-1], smp_b});
        diff_w    = PROD_W'(diff);
        inv_w     = PROD_W'($signed({1'b0, inv_sel}));
        prod_next = diff_w * inv_w;
        shifted   = both_prev ? (prod_reg >>> 9) : (prod_reg >>> 8);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            cmd_reg   <= '0;
            prod_reg  <= '0;
            err_reg   <= 1'b0;
            done_reg  <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                smp_reg[i] <= '0;
            end
            for (int i = 0; i < 3; i++)
            begin
                grad_reg[i] <= '0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg  <= q_cmd;
                        err_reg  <= q_cmd.index_error;
                        step_reg <= '0;
                        for (int i = 0; i < 3; i++)
                        begin
                            grad_reg[i] <= '0;
                        end
                        unique case (q_cmd.kind)
                            vgcd_pkg::KIND_WRITE: state_reg <= ST_WRITE;
                            vgcd_pkg::KIND_QUERY: state_reg <= ST_READ;
                            default:              state_reg <= ST_OUT;
                        endcase
                    end
                end
                ST_WRITE:
                begin
                    state_reg <= ST_OUT;
                end
                ST_READ:
                begin
                    if (step_reg != '0)
                    begin
                        smp_reg[3'(step_reg - 3'd1)] <= $signed(mem_q);
                    end
                    if (step_reg == 3'd6)
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_MUL;
                    end
                    else
                    begin
                        step_reg <= step_reg + 3'd1;
                    end
                end
                ST_MUL:
                begin
                    prod_reg <= prod_next;
                    if (step_reg != '0)
                    begin
                        grad_reg[2'(step_reg - 3'd1)] <= shifted[vgcd_pkg::GRAD_W-1:0];
                    end
                    if (step_reg == 3'd3)
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        step_reg <= step_reg + 3'd1;
                    end
                end
                ST_OUT:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done        = done_reg;
    assign grad_x      = grad_reg[0];
    assign grad_y      = grad_reg[1];
    assign grad_z      = grad_reg[2];
    assign index_error = err_reg;

    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe held longer than one cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && index_error) |-> (grad_x == '0 && grad_y == '0 && grad_z == '0))
        else $error("nonzero gradient on an out-of-grid word");

    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !cmd_reg.index_error)
        else $error("store written for an out-of-grid node");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (cmd_reg.kind == vgcd_pkg::KIND_QUERY))
        else $error("neighbor read outside a query");

endmodule

// ----- dv/volume_gradient_central_difference_tb.sv -----
`timescale 1ns / 1ps

module volume_gradient_central_difference_tb;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam int AX_X = 0;
    localparam int AX_Y = 1;
    localparam int AX_Z = 2;

    localparam int STALL_LIMIT  = 4000;
    localparam int PHASE_COUNT  = 10;
    localparam int PHASE_ITEMS  = 130;
    localparam int SECOND_SETUP = 18;

    typedef struct packed {
        logic signed [vgcd_pkg::GRAD_W-1:0] gx;
        logic signed [vgcd_pkg::GRAD_W-1:0] gy;
        logic signed [vgcd_pkg::GRAD_W-1:0] gz;
        logic                               err;
    } grad_word_t;

    typedef struct packed {
        logic                          act;
        logic [vgcd_pkg::NODE_W-1:0]   x;
        logic [vgcd_pkg::NODE_W-1:0]   y;
        logic [vgcd_pkg::NODE_W-1:0]   z;
        logic [vgcd_pkg::SAMPLE_W-1:0] smp;
        logic                          typed;
        grad_word_t                    want;
    } dir_row_t;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 start;
    logic                                 busy;
    logic                                 action;
    logic [vgcd_pkg::NODE_W-1:0]          node_x;
    logic [vgcd_pkg::NODE_W-1:0]          node_y;
    logic [vgcd_pkg::NODE_W-1:0]          node_z;
    logic signed [vgcd_pkg::SAMPLE_W-1:0] sample;
    logic                                 done;
    logic signed [vgcd_pkg::GRAD_W-1:0]   grad_x;
    logic signed [vgcd_pkg::GRAD_W-1:0]   grad_y;
    logic signed [vgcd_pkg::GRAD_W-1:0]   grad_z;
    logic                                 index_error;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [vgcd_pkg::CFG_IDX_W-1:0]       cfg_index;
    logic [vgcd_pkg::INV_W-1:0]           cfg_data;

    logic [vgcd_pkg::SAMPLE_W-1:0] sdf_mem [0:vgcd_pkg::STORE_DEPTH-1];
    bit                            sdf_set [0:vgcd_pkg::STORE_DEPTH-1];
    logic [vgcd_pkg::SIZE_W-1:0]   size_reg [3];
    logic [vgcd_pkg::INV_W-1:0]    inv_reg [3];

    grad_word_t grad_queue [$];
    dir_row_t   dir_rows [$];
    grad_word_t head_word;
    int         mismatches;
    int         sent;
    int         idle_cycles;
    bit         no_gaps;

    volume_gradient_central_difference dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .node_x      (node_x),
        .node_y      (node_y),
        .node_z      (node_z),
        .sample      (sample),
        .done        (done),
        .grad_x      (grad_x),
        .grad_y      (grad_y),
        .grad_z      (grad_z),
        .index_error (index_error),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int grid_extent(input logic [vgcd_pkg::SIZE_W-1:0] s);
        int e;
        e = int'(s);
        if (e == 0)
        begin
            e = 1;
        end
        else if (e > vgcd_pkg::MAX_AXIS_NODES)
        begin
            e = vgcd_pkg::MAX_AXIS_NODES;
        end
        return e;
    endfunction

    function automatic int node_addr(input int x, input int y, input int z);
        return x + vgcd_pkg::MAX_AXIS_NODES * (y + vgcd_pkg::MAX_AXIS_NODES * z);
    endfunction

    function automatic longint node_level(input int x, input int y, input int z);
        return longint'(signed'(sdf_mem[node_addr(x, y, z)]));
    endfunction

    function automatic longint axis_slope(input int x, input int y, input int z,
                                          input int axis, input int extent,
                                          input logic [vgcd_pkg::INV_W-1:0] inv);
        int     hx, hy, hz, lx, ly, lz, c, cnt;
        longint diff, prod;
        hx = x;
        hy = y;
        hz = z;
        lx = x;
        ly = y;
        lz = z;
        cnt = 0;
        c = (axis == AX_X) ? x : (axis == AX_Y) ? y : z;
        if (c + 1 < extent)
        begin
            cnt++;
            case (axis)
                AX_X: hx = x + 1;
                AX_Y: hy = y + 1;
                default: hz = z + 1;
            endcase
        end
        if (c > 0)
        begin
            cnt++;
            case (axis)
                AX_X: lx = x - 1;
                AX_Y: ly = y - 1;
                default: lz = z - 1;
            endcase
        end
        if (cnt == 0)
        begin
            return 0;
        end
        diff = node_level(hx, hy, hz) - node_level(lx, ly, lz);
        prod = (diff * longint'(inv)) >>> 8;
        if (cnt == 2)
        begin
            prod = prod >>> 1;
        end
        return prod;
    endfunction

    function automatic grad_word_t volume_step(input logic act, input int x, input int y,
                                               input int z,
                                               input logic [vgcd_pkg::SAMPLE_W-1:0] smp);
        grad_word_t w;
        int         ex, ey, ez, a;
        ex = grid_extent(size_reg[AX_X]);
        ey = grid_extent(size_reg[AX_Y]);
        ez = grid_extent(size_reg[AX_Z]);
        w = '0;
        w.err = (x >= ex) || (y >= ey) || (z >= ez);
        if (!w.err)
        begin
            if (act == ACT_WRITE)
            begin
                a = node_addr(x, y, z);
                sdf_mem[a] = smp;
                sdf_set[a] = 1'b1;
            end
            else
            begin
                w.gx = vgcd_pkg::GRAD_W'(axis_slope(x, y, z, AX_X, ex, inv_reg[AX_X]));
                w.gy = vgcd_pkg::GRAD_W'(axis_slope(x, y, z, AX_Y, ey, inv_reg[AX_Y]));
                w.gz = vgcd_pkg::GRAD_W'(axis_slope(x, y, z, AX_Z, ez, inv_reg[AX_Z]));
            end
        end
        return w;
    endfunction

    function automatic logic [vgcd_pkg::SAMPLE_W-1:0] rand_sample();
        logic [vgcd_pkg::SAMPLE_W-1:0] v;
        v = vgcd_pkg::SAMPLE_W'($urandom);
        case ($urandom_range(0, 11))
            0: v = 16'h7FFF;
            1: v = 16'h8000;
            2: v = 16'hFFFF;
            3: v = 16'h0000;
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [vgcd_pkg::SIZE_W-1:0] rand_size();
        logic [vgcd_pkg::SIZE_W-1:0] s;
        case ($urandom_range(0, 19))
            0: s = 6'd0;
            1: s = 6'd1;
            2, 3: s = 6'd32;
            4: s = vgcd_pkg::SIZE_W'($urandom_range(33, 63));
            5, 6, 7: s = vgcd_pkg::SIZE_W'($urandom_range(7, 31));
            default: s = vgcd_pkg::SIZE_W'($urandom_range(2, 6));
        endcase
        return s;
    endfunction

    function automatic logic [vgcd_pkg::INV_W-1:0] rand_inv();
        logic [vgcd_pkg::INV_W-1:0] v;
        case ($urandom_range(0, 19))
            0: v = 16'h0000;
            1: v = 16'h0001;
            2: v = 16'hFFFF;
            3: v = 16'h0100;
            4, 5: v = vgcd_pkg::INV_W'($urandom);
            default: v = vgcd_pkg::INV_W'($urandom_range(1, 1023));
        endcase
        return v;
    endfunction

    function automatic logic [vgcd_pkg::INV_W-1:0] pad_size(
        input logic [vgcd_pkg::SIZE_W-1:0] s);
        logic [vgcd_pkg::INV_W-1:0] v;
        v = vgcd_pkg::INV_W'($urandom);
        v[vgcd_pkg::SIZE_W-1:0] = s;
        return v;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
        begin
            return 0;
        end
        else if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Hand one word to the block; returns at the edge that takes it, start held high.
    task automatic send(input logic act, input int x, input int y, input int z,
                        input logic [vgcd_pkg::SAMPLE_W-1:0] smp);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start  <= 1'b1;
        action <= act;
        node_x <= vgcd_pkg::NODE_W'(x);
        node_y <= vgcd_pkg::NODE_W'(y);
        node_z <= vgcd_pkg::NODE_W'(z);
        sample <= smp;
        do @(posedge clk); while (busy);
        grad_queue.insert(grad_queue.size(), volume_step(act, x, y, z, smp));
        sent++;
    endtask

    task automatic drain(input int tail);
        start <= 1'b0;
        do @(posedge clk); while (grad_queue.size() != 0);
        repeat (tail) @(posedge clk);
    endtask

    task automatic write_reg(input logic [vgcd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [vgcd_pkg::INV_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            vgcd_pkg::CFG_SIZE_X:        size_reg[AX_X] = data[vgcd_pkg::SIZE_W-1:0];
            vgcd_pkg::CFG_SIZE_Y:        size_reg[AX_Y] = data[vgcd_pkg::SIZE_W-1:0];
            vgcd_pkg::CFG_SIZE_Z:        size_reg[AX_Z] = data[vgcd_pkg::SIZE_W-1:0];
            vgcd_pkg::CFG_INV_SPACING_X: inv_reg[AX_X] = data;
            vgcd_pkg::CFG_INV_SPACING_Y: inv_reg[AX_Y] = data;
            vgcd_pkg::CFG_INV_SPACING_Z: inv_reg[AX_Z] = data;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_grid(input logic [vgcd_pkg::SIZE_W-1:0] sx,
                            input logic [vgcd_pkg::SIZE_W-1:0] sy,
                            input logic [vgcd_pkg::SIZE_W-1:0] sz,
                            input logic [vgcd_pkg::INV_W-1:0] ix,
                            input logic [vgcd_pkg::INV_W-1:0] iy,
                            input logic [vgcd_pkg::INV_W-1:0] iz);
        drain(20);
        write_reg(vgcd_pkg::CFG_SIZE_X, pad_size(sx));
        write_reg(vgcd_pkg::CFG_SIZE_Y, pad_size(sy));
        write_reg(vgcd_pkg::CFG_SIZE_Z, pad_size(sz));
        write_reg(vgcd_pkg::CFG_INV_SPACING_X, ix);
        write_reg(vgcd_pkg::CFG_INV_SPACING_Y, iy);
        write_reg(vgcd_pkg::CFG_INV_SPACING_Z, iz);
    endtask

    task automatic prime_node(input int x, input int y, input int z);
        if (!sdf_set[node_addr(x, y, z)])
        begin
            send(ACT_WRITE, x, y, z, rand_sample());
        end
    endtask

    task automatic add_row(input logic act, input int x, input int y, input int z,
                           input logic [vgcd_pkg::SAMPLE_W-1:0] smp, input logic typed,
                           input int gx, input int gy, input int gz, input logic err);
        dir_row_t r;
        r.act     = act;
        r.x       = vgcd_pkg::NODE_W'(x);
        r.y       = vgcd_pkg::NODE_W'(y);
        r.z       = vgcd_pkg::NODE_W'(z);
        r.smp     = smp;
        r.typed   = typed;
        r.want.gx = vgcd_pkg::GRAD_W'(gx);
        r.want.gy = vgcd_pkg::GRAD_W'(gy);
        r.want.gz = vgcd_pkg::GRAD_W'(gz);
        r.want.err = err;
        dir_rows.insert(dir_rows.size(), r);
    endtask

    task automatic run_phase(input int items);
        int  target, ex, ey, ez, a, x, y, z, pick;
        bit  paused;
        ex = grid_extent(size_reg[AX_X]);
        ey = grid_extent(size_reg[AX_Y]);
        ez = grid_extent(size_reg[AX_Z]);
        no_gaps = ($urandom_range(0, 3) == 0);
        paused = 1'b0;
        target = sent + items;
        while (sent < target)
        begin
            if (!paused && sent >= target - items / 2)
            begin
                drain(0);
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 12 && (ex < vgcd_pkg::MAX_AXIS_NODES || ey < vgcd_pkg::MAX_AXIS_NODES
                              || ez < vgcd_pkg::MAX_AXIS_NODES))
            begin
                x = $urandom_range(0, 31);
                y = $urandom_range(0, 31);
                z = $urandom_range(0, 31);
                do a = $urandom_range(0, 2);
                while ((a == AX_X && ex == vgcd_pkg::MAX_AXIS_NODES)
                       || (a == AX_Y && ey == vgcd_pkg::MAX_AXIS_NODES)
                       || (a == AX_Z && ez == vgcd_pkg::MAX_AXIS_NODES));
                case (a)
                    AX_X: x = $urandom_range(ex, 31);
                    AX_Y: y = $urandom_range(ey, 31);
                    default: z = $urandom_range(ez, 31);
                endcase
                send(1'($urandom_range(0, 1)), x, y, z, rand_sample());
            end
            else if (pick < 45)
            begin
                send(ACT_WRITE, $urandom_range(0, ex - 1), $urandom_range(0, ey - 1),
                     $urandom_range(0, ez - 1), rand_sample());
            end
            else
            begin
                x = $urandom_range(0, ex - 1);
                y = $urandom_range(0, ey - 1);
                z = $urandom_range(0, ez - 1);
                prime_node(x, y, z);
                if (x > 0) prime_node(x - 1, y, z);
                if (x + 1 < ex) prime_node(x + 1, y, z);
                if (y > 0) prime_node(x, y - 1, z);
                if (y + 1 < ey) prime_node(x, y + 1, z);
                if (z > 0) prime_node(x, y, z - 1);
                if (z + 1 < ez) prime_node(x, y, z + 1);
                send(ACT_QUERY, x, y, z, rand_sample());
            end
        end
        no_gaps = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (grad_queue.size() == 0)
            begin
                $display("%0t unexpected word: grad %0d %0d %0d err %0b",
                         $time, grad_x, grad_y, grad_z, index_error);
                mismatches++;
            end
            else
            begin
                head_word = grad_queue.pop_front();
                if (head_word.gx !== grad_x)
                begin
                    $display("%0t grad_x expected %0d got %0d", $time, head_word.gx, grad_x);
                    mismatches++;
                end
                if (head_word.gy !== grad_y)
                begin
                    $display("%0t grad_y expected %0d got %0d", $time, head_word.gy, grad_y);
                    mismatches++;
                end
                if (head_word.gz !== grad_z)
                begin
                    $display("%0t grad_z expected %0d got %0d", $time, head_word.gz, grad_z);
                    mismatches++;
                end
                if (head_word.err !== index_error)
                begin
                    $display("%0t index_error expected %0b got %0b",
                             $time, head_word.err, index_error);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready) || !rst_n)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int       i, p;
        dir_row_t r;
        rst_n      <= 1'b0;
        start      <= 1'b0;
        action     <= ACT_WRITE;
        node_x     <= '0;
        node_y     <= '0;
        node_z     <= '0;
        sample     <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= vgcd_pkg::CFG_SIZE_X;
        cfg_data   <= '0;
        mismatches = 0;
        sent       = 0;
        idle_cycles = 0;
        no_gaps    = 1'b0;
        for (i = 0; i < 3; i++)
        begin
            size_reg[i] = vgcd_pkg::SIZE_RESET;
            inv_reg[i]  = vgcd_pkg::INV_RESET;
        end

        // reset grid: corner, an interior node and far corner
        add_row(ACT_WRITE, 0, 0, 0, 16'h7FFF, 1'b1, 0, 0, 0, 1'b0);
        add_row(ACT_WRITE, 1, 0, 0, 16'h8000, 1'b1, 0, 0, 0, 1'b0);
        add_row(ACT_WRITE, 0, 1, 0, 16'h7FFF, 1'b1, 0, 0, 0, 1'b0);
        add_row(ACT_WRITE, 0, 0, 1, 16'h8000, 1'b1, 0, 0, 0, 1'b0);
        add_row(ACT_QUERY, 0, 0, 0, 16'h0000, 1'b1, -65535, 0, -65535, 1'b0);
        add_row(ACT_WRITE, 4, 5, 5, 16'h0003, 1'b0, 0, 0, 0, 1'b0);
        add_row(ACT_WRITE, 6, 5, 5, 16'h0000, 1'b0, 0, 0, 0, 1'b0);
        add_row(ACT_WRITE, 5, 4, 5, 16'h1234, 1'b0, 0, 0, 0, 1'b0);
        add_row(ACT_WRITE, 5, 6, 5, 16'hF00D, 1'b0, 0, 0, 0, 1'b0);
        add_row(ACT_WRITE, 5, 5, 4, 16'h7FFF, 1'b0, 0, 0, 0, 1'b0);
        add_row(ACT_WRITE, 5, 5, 6, 16'h8000, 1'b0, 0, 0, 0, 1'b0);
        add_row(ACT_WRITE, 5, 5, 5, 16'h0101, 1'b0, 0, 0, 0, 1'b0);
        add_row(ACT_QUERY, 5, 5, 5, 16'hFFFF, 1'b0, 0, 0, 0, 1'b0);
        add_row(ACT_WRITE, 31, 31, 31, 16'h8000, 1'b0, 0, 0, 0, 1'b0);
        add_row(ACT_WRITE, 30, 31, 31, 16'h7FFF, 1'b0, 0, 0, 0, 1'b0);
        add_row(ACT_WRITE, 31, 30, 31, 16'h0001, 1'b0, 0, 0, 0, 1'b0);
        add_row(ACT_WRITE, 31, 31, 30, 16'hFFFF, 1'b0, 0, 0, 0, 1'b0);
        add_row(ACT_QUERY, 31, 31, 31, 16'h5555, 1'b0, 0, 0, 0, 1'b0);
        // narrow grid: x collapsed, y saturated, z of two
        add_row(ACT_WRITE, 1, 0, 0, 16'h0005, 1'b1, 0, 0, 0, 1'b1);
        add_row(ACT_QUERY, 0, 0, 2, 16'hAAAA, 1'b1, 0, 0, 0, 1'b1);
        add_row(ACT_WRITE, 0, 1, 0, 16'h8000, 1'b0, 0, 0, 0, 1'b0);
        add_row(ACT_QUERY, 0, 0, 0, 16'h0000, 1'b0, 0, 0, 0, 1'b0);
        add_row(ACT_QUERY, 5, 0, 0, 16'h0000, 1'b1, 0, 0, 0, 1'b1);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < dir_rows.size(); i++)
        begin
            if (i == SECOND_SETUP)
            begin
                set_grid(6'd0, 6'd40, 6'd2, 16'h0001, 16'hFFFF, 16'h0000);
            end
            r = dir_rows[i];
            send(r.act, r.x, r.y, r.z, r.smp);
            if (r.typed)
            begin
                grad_queue[grad_queue.size() - 1] = r.want;
            end
        end

        for (p = 0; p < PHASE_COUNT; p++)
        begin
            if (p == 0)
            begin
                set_grid(6'd32, 6'd1, 6'd63, 16'hFFFF, 16'h0100, 16'h0001);
            end
            else if (p == PHASE_COUNT - 1)
            begin
                set_grid(6'd2, 6'd2, 6'd32, 16'h0000, 16'hFFFF, 16'h8000);
            end
            else
            begin
                set_grid(rand_size(), rand_size(), rand_size(), rand_inv(), rand_inv(),
                         rand_inv());
            end
            run_phase(PHASE_ITEMS);
        end

        drain(24);
        if (mismatches == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/vgcd_pkg.sv
hw/rtl/vgcd_front.sv
hw/rtl/vgcd_queue.sv
hw/rtl/vgcd_back.sv
hw/rtl/volume_gradient_central_difference.sv
dv/volume_gradient_central_difference_tb.sv
